// ----- rtl/rfd_pkg.sv -----
// Shared types and constants for the resync frame deframer.
`timescale 1ns / 1ps
package rfd_pkg;

  localparam int BUFFER_DEPTH_DEF = 64;
  localparam int FRAME_OVERHEAD   = 6;
  localparam int BYTE_W           = 8;
  localparam int LEN_W            = 6;
  localparam int CFG_IDX_W        = 2;
  localparam int OUT_TDATA_W      = 24;
  localparam int OUT_TUSER_W      = 9;

  localparam logic [CFG_IDX_W-1:0] CFG_HEAD1 = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEAD2 = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TAIL  = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHK,
    S_H1,
    S_H2,
    S_LEN,
    S_TAIL,
    S_SUM,
    S_EMIT,
    S_FIN
  } rfd_state_t;

  typedef struct packed {
    logic [BYTE_W-1:0] cmd;
    logic [BYTE_W-1:0] data;
    logic [LEN_W-1:0]  pos;
    logic [LEN_W-1:0]  len;
    logic              frame_end;
  } rfd_res_t;

  typedef struct packed {
    logic     push;
    logic     fin;
    rfd_res_t res;
  } rfd_emit_t;

endpackage

// ----- rtl/rfd_mem.sv -----
// Byte buffer memory: one write port, one read port with registered data.
`timescale 1ns / 1ps
module rfd_mem #(
  parameter int DEPTH = rfd_pkg::BUFFER_DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [AW-1:0]              waddr,
  input  logic [rfd_pkg::BYTE_W-1:0] wdata,
  input  logic                       re,
  input  logic [AW-1:0]              raddr,
  output logic [rfd_pkg::BYTE_W-1:0] rdata
);
  import rfd_pkg::*;

  logic [BYTE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/rfd_out.sv -----
// Result hold stage and output register; marks run end when the scan finishes.
`timescale 1ns / 1ps
module rfd_out (
  input  logic                                clk,
  input  logic                                rst,
  input  rfd_pkg::rfd_emit_t                  emit,
  output logic                                stage_ok,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [rfd_pkg::OUT_TDATA_W-1:0]     m_tdata,   // payload_byte, byte_position, payload_length
  output logic [rfd_pkg::OUT_TUSER_W-1:0]     m_tuser,   // frame_command, run_end
  output logic                                m_tlast    // frame_end
);
  import rfd_pkg::*;

  logic     hold_valid;
  rfd_res_t hold;
  logic     out_free;
  logic     move;

  assign out_free = !m_tvalid || m_tready;
  assign stage_ok = !hold_valid || out_free;
  assign move     = hold_valid && out_free && (emit.push || emit.fin);

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      if (emit.push) begin
        hold_valid <= 1'b1;
      end else if (emit.fin) begin
        hold_valid <= 1'b0;
      end
      if (move) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit.push) begin
      hold <= emit.res;
    end
    if (move) begin
      m_tdata <= {4'b0000, hold.len, hold.pos, hold.data};
      m_tuser <= {emit.fin, hold.cmd};
      m_tlast <= hold.frame_end;
    end
  end

  a_push_ok: assert property (@(posedge clk) disable iff (rst)
    emit.push |-> stage_ok) else $error("result pushed while hold stage blocked");
  a_fin_ok: assert property (@(posedge clk) disable iff (rst)
    emit.fin |-> stage_ok) else $error("finish while hold stage blocked");
  a_fin_clears: assert property (@(posedge clk) disable iff (rst)
    emit.fin |=> !hold_valid) else $error("hold stage kept a result after finish");

endmodule

// ----- rtl/rfd_scan.sv -----
// Frame scanner: buffer pointers, config registers and the read-modify sequencer.
`timescale 1ns / 1ps
module rfd_scan #(
  parameter int DEPTH = rfd_pkg::BUFFER_DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH),
  parameter int FW    = $clog2(DEPTH + 1)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic                          cfg_we,
  input  logic [rfd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rfd_pkg::BYTE_W-1:0]    cfg_data,
  output logic                          mem_we,
  output logic [AW-1:0]                 mem_waddr,
  output logic                          mem_re,
  output logic [AW-1:0]                 mem_raddr,
  input  logic [rfd_pkg::BYTE_W-1:0]    mem_rdata,
  input  logic                          stage_ok,
  output rfd_pkg::rfd_emit_t            emit
);
  import rfd_pkg::*;

  rfd_state_t        state, state_next;
  logic [AW-1:0]     head;
  logic [FW-1:0]     fill;
  logic [AW-1:0]     off;
  logic [LEN_W-1:0]  len;
  logic [BYTE_W-1:0] sum;
  logic [BYTE_W-1:0] cmd;
  logic [BYTE_W-1:0] head1, head2, tail;

  logic          accept, drop1, dropf;
  logic [AW-1:0] rd_off;
  logic [8:0]    flen_rd;
  logic [8:0]    off9;
  logic [8:0]    len9;
  logic          sum_last, emit_last, len_bad, fill_full;

  function automatic logic [AW-1:0] wrap(input logic [AW:0] s);
    logic [AW:0] d;
    d = s - (AW+1)'(DEPTH);
    return (s >= (AW+1)'(DEPTH)) ? d[AW-1:0] : s[AW-1:0];
  endfunction

  assign accept    = s_tvalid && s_tready;
  assign flen_rd   = {1'b0, mem_rdata} + 9'(FRAME_OVERHEAD);
  assign off9      = 9'(off);
  assign len9      = 9'(len);
  assign sum_last  = off9 == len9 + 9'd4;
  assign emit_last = off9 == len9 + 9'd3;
  assign len_bad   = (mem_rdata == '0) || (flen_rd > 9'(DEPTH));
  assign fill_full = fill == FW'(DEPTH);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (accept) state_next = S_CHK;
      S_CHK:  state_next = (fill < FW'(FRAME_OVERHEAD)) ? S_FIN : S_H1;
      S_H1:   state_next = (mem_rdata != head1) ? S_CHK : S_H2;
      S_H2:   state_next = (mem_rdata != head2) ? S_CHK : S_LEN;
      S_LEN: begin
        if (len_bad) state_next = S_CHK;
        else if (9'(fill) < flen_rd) state_next = S_FIN;
        else state_next = S_TAIL;
      end
      S_TAIL: state_next = (mem_rdata != tail) ? S_CHK : S_SUM;
      S_SUM: begin
        if (sum_last) state_next = (mem_rdata != sum) ? S_CHK : S_EMIT;
      end
      S_EMIT: if (stage_ok && emit_last) state_next = S_CHK;
      S_FIN:  if (stage_ok) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    s_tready  = 1'b0;
    mem_re    = 1'b0;
    rd_off    = '0;
    drop1     = 1'b0;
    dropf     = 1'b0;
    emit.push = 1'b0;
    emit.fin  = 1'b0;
    emit.res  = '{cmd: cmd, data: mem_rdata, pos: LEN_W'(off9 - 9'd4), len: len,
                  frame_end: emit_last};
    unique case (state)
      S_IDLE: s_tready = 1'b1;
      S_CHK: begin
        mem_re = fill >= FW'(FRAME_OVERHEAD);
      end
      S_H1: begin
        drop1  = mem_rdata != head1;
        mem_re = 1'b1;
        rd_off = AW'(1);
      end
      S_H2: begin
        drop1  = mem_rdata != head2;
        mem_re = 1'b1;
        rd_off = AW'(3);
      end
      S_LEN: begin
        drop1  = len_bad;
        mem_re = 1'b1;
        rd_off = AW'(mem_rdata + 8'd5);
      end
      S_TAIL: begin
        drop1  = mem_rdata != tail;
        mem_re = 1'b1;
      end
      S_SUM: begin
        mem_re = 1'b1;
        if (sum_last) begin
          drop1  = mem_rdata != sum;
          rd_off = AW'(4);
        end else begin
          rd_off = off + AW'(1);
        end
      end
      S_EMIT: begin
        if (stage_ok) begin
          emit.push = 1'b1;
          dropf     = emit_last;
          mem_re    = !emit_last;
          rd_off    = off + AW'(1);
        end
      end
      S_FIN: emit.fin = stage_ok;
      default: ;
    endcase
  end

  assign mem_raddr = wrap({1'b0, head} + {1'b0, rd_off});
  assign mem_we    = accept;
  assign mem_waddr = fill_full ? head : wrap({1'b0, head} + (AW+1)'(fill));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      head  <= '0;
      fill  <= '0;
      head1 <= 8'd170;
      head2 <= 8'd85;
      tail  <= 8'd13;
    end else begin
      state <= state_next;
      if (accept) begin
        if (fill_full) head <= wrap({1'b0, head} + (AW+1)'(1));
        else fill <= fill + FW'(1);
      end else if (drop1) begin
        head <= wrap({1'b0, head} + (AW+1)'(1));
        fill <= fill - FW'(1);
      end else if (dropf) begin
        head <= wrap({1'b0, head} + (AW+1)'(len) + (AW+1)'(FRAME_OVERHEAD));
        fill <= fill - FW'(len) - FW'(FRAME_OVERHEAD);
      end
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_HEAD1: head1 <= cfg_data;
          CFG_HEAD2: head2 <= cfg_data;
          CFG_TAIL:  tail  <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) off <= rd_off;
    if (state == S_LEN) len <= LEN_W'(mem_rdata);
    if (state == S_TAIL) begin
      sum <= '0;
    end else if (state == S_SUM && !sum_last) begin
      sum <= sum + mem_rdata;
      if (off == AW'(2)) cmd <= mem_rdata;
    end
  end

  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    fill <= FW'(DEPTH)) else $error("fill count above buffer depth");
  a_push_state: assert property (@(posedge clk) disable iff (rst)
    emit.push |-> state == S_EMIT) else $error("result outside emit phase");
  a_frame_drop: assert property (@(posedge clk) disable iff (rst)
    dropf |=> state == S_CHK && fill == $past(fill) - FW'($past(len)) - FW'(FRAME_OVERHEAD))
    else $error("frame removal wrong");
  a_accept_write: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> !mem_re) else $error("write and read in the same cycle");

endmodule

// ----- rtl/resync_frame_deframer.sv -----
// Top level of the resync frame deframer.
//
// Input words on s_tvalid/s_tready/s_tdata are received link bytes. Each
// accepted byte is appended to a circular byte buffer and the buffer front is
// scanned for head1, head2, command, length, payload, checksum, tail frames.
// Bad fronts lose one byte and the scan repeats; a good frame sends out one
// word per payload byte on m_tvalid/m_tready, then is removed.
// m_tlast marks the last payload byte of a frame, m_tuser[8] the last word
// caused by one input byte. Sync and tail bytes are set through cfg_we,
// cfg_index and cfg_data (0 head1, 1 head2, 2 tail); the user must write them
// only while idle, as the block itself does not enforce it.
// The input is taken one byte at a time: a new byte is accepted only when the
// scan for the last one has finished. A frame takes five header and tail
// steps, a checksum walk of length + 5 reads and one payload word per cycle
// while the receiver keeps up, all set by the single read port of the buffer
// memory. Each word waits in the hold stage until the next word or the finish
// moves it to the output register, so the final word of a run leaves when the
// scan finishes. Reset clears fill count, pointers and output valid; the
// buffer needs no clearing. A stalled receiver holds the scan in its emit
// or finish step and the input stays not ready.
`timescale 1ns / 1ps
module resync_frame_deframer #(
  parameter int BUFFER_DEPTH = rfd_pkg::BUFFER_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [7:0]                      s_tdata,   // rx_byte
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [rfd_pkg::OUT_TDATA_W-1:0] m_tdata,   // payload_byte, byte_position, payload_length
  output logic [rfd_pkg::OUT_TUSER_W-1:0] m_tuser,   // frame_command, run_end
  output logic                            m_tlast,   // frame_end
  input  logic                            cfg_we,
  input  logic [rfd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rfd_pkg::BYTE_W-1:0]      cfg_data
);
  import rfd_pkg::*;

  localparam int AW = $clog2(BUFFER_DEPTH);

  logic              mem_we, mem_re, stage_ok;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  logic [BYTE_W-1:0] mem_rdata;
  rfd_emit_t         emit;

  rfd_mem #(.DEPTH(BUFFER_DEPTH), .AW(AW)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (s_tdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  rfd_scan #(.DEPTH(BUFFER_DEPTH), .AW(AW)) u_scan (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata),
    .stage_ok  (stage_ok),
    .emit      (emit)
  );

  rfd_out u_out (
    .clk      (clk),
    .rst      (rst),
    .emit     (emit),
    .stage_ok (stage_ok),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

// ----- tb/tb_resync_frame_deframer.sv -----
// Self-checking testbench for the resync frame deframer: predicted payload words vs DUT.
`timescale 1ns / 1ps
module tb_resync_frame_deframer;
  import rfd_pkg::*;

  typedef struct packed {
    logic [7:0] cmd;
    logic [7:0] data;
    logic [5:0] pos;
    logic [5:0] len;
    logic       fend;
    logic       rend;
  } payload_word_t;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;
  logic [8:0]  m_tuser;
  logic        m_tlast;
  logic        cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_HEAD1;
  logic [7:0]  cfg_data = '0;

  resync_frame_deframer u_top (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  logic [7:0] sync1 = 8'd170, sync2 = 8'd85, tail = 8'd13;
  logic [7:0] rx_buf[$];
  payload_word_t pending_words[$];
  int errors = 0;
  bit quiet = 0;
  bit hold_off = 0;

  function automatic void predict_byte(input logic [7:0] b);
    int len, flen;
    logic [7:0] sum;
    int n0;
    n0 = pending_words.size();
    if (rx_buf.size() >= 64) void'(rx_buf.pop_front());
    rx_buf.push_back(b);
    while (rx_buf.size() >= 6) begin
      if (rx_buf[0] != sync1 || rx_buf[1] != sync2) begin
        void'(rx_buf.pop_front()); continue;
      end
      len = rx_buf[3];
      flen = len + 6;
      if (len == 0 || flen > 64) begin
        void'(rx_buf.pop_front()); continue;
      end
      if (rx_buf.size() < flen) break;
      if (rx_buf[flen-1] != tail) begin
        void'(rx_buf.pop_front()); continue;
      end
      sum = '0;
      for (int i = 0; i < flen - 2; i++) sum += rx_buf[i];
      if (sum != rx_buf[flen-2]) begin
        void'(rx_buf.pop_front()); continue;
      end
      for (int i = 0; i < len; i++)
        pending_words.push_back('{rx_buf[2], rx_buf[4+i], i[5:0], len[5:0],
                                  (i == len - 1), 1'b0});
      for (int i = 0; i < flen; i++) void'(rx_buf.pop_front());
    end
    if (pending_words.size() > n0) pending_words[$].rend = 1'b1;
  endfunction

  task automatic send_byte(input logic [7:0] b);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    do @(posedge clk); while (!s_tready);
    predict_byte(b);
  endtask

  task automatic send_frame(input logic [7:0] cmd, input int len, input bit corrupt);
    logic [7:0] fr[$];
    logic [7:0] sum;
    fr = '{sync1, sync2, cmd, len[7:0]};
    for (int i = 0; i < len; i++) fr.push_back(8'($urandom_range(0, 255)));
    sum = '0;
    foreach (fr[i]) sum += fr[i];
    fr.push_back(corrupt && $urandom_range(0, 1) ? sum + 8'd1 : sum);
    fr.push_back(corrupt && sum[0] ? ~tail : tail);
    foreach (fr[i]) send_byte(fr[i]);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_HEAD1: sync1 = v;
      CFG_HEAD2: sync2 = v;
      CFG_TAIL:  tail  = v;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic test_directed();
    send_frame(8'h00, 1, 0);
    send_frame(8'hFF, 58, 0);
    send_byte(sync1); send_byte(sync2); send_byte(8'h11); send_byte(8'h00);
    send_byte(8'h00); send_byte(8'h00);
    send_byte(sync1); send_byte(sync2); send_byte(8'h22); send_byte(8'd59);
    send_frame(8'h5A, 2, 0);
    drain();
  endtask

  task automatic test_config_extremes();
    write_reg(CFG_HEAD1, 8'h00);
    write_reg(CFG_HEAD2, 8'hFF);
    write_reg(CFG_TAIL, 8'h00);
    write_reg(CFG_UNUSED, 8'h77);
    send_frame(8'hA5, 3, 0);
    send_frame(8'h3C, 1, 1);
    send_frame(8'hC3, 4, 0);
    drain();
    write_reg(CFG_HEAD1, 8'hFF);
    write_reg(CFG_HEAD2, 8'h00);
    write_reg(CFG_TAIL, 8'hFF);
    send_frame(8'h01, 5, 0);
    drain();
  endtask

  task automatic test_random();
    int sent;
    write_reg(CFG_HEAD1, 8'($urandom_range(0, 255)));
    write_reg(CFG_HEAD2, 8'($urandom_range(0, 255)));
    write_reg(CFG_TAIL, 8'($urandom_range(0, 255)));
    sent = 0;
    while (sent < 40) begin
      if ($urandom_range(0, 4) == 0) begin
        send_byte(8'($urandom_range(0, 255))); sent++;
      end else begin
        int l;
        l = $urandom_range(0, 9) == 0 ? $urandom_range(1, 58) : $urandom_range(1, 6);
        send_frame(8'($urandom_range(0, 255)), l, $urandom_range(0, 4) == 0);
        sent += l + 6;
      end
    end
    drain();
  endtask

  task automatic test_backpressure();
    hold_off = 1;
    repeat (2) send_frame(8'($urandom_range(0, 255)), 10, 0);
    hold_off = 0;
    quiet = 1;
    repeat (2) send_frame(8'($urandom_range(0, 255)), $urandom_range(1, 10), 0);
    drain();
  endtask

  // receiver
  initial begin
    int gap;
    forever begin
      @(posedge clk);
      if (hold_off) begin
        m_tready <= 1'b0;
        for (gap = 0; gap < 1500; gap++) @(posedge clk);
        hold_off = 0;
        m_tready <= 1'b1;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
        m_tready <= 1'b1;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    payload_word_t exp_w;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_words.size() == 0) begin
        $error("unexpected word %h", m_tdata);
        errors++;
      end else begin
        exp_w = pending_words.pop_front();
        if (m_tuser[7:0] != exp_w.cmd) begin
          $error("frame_command exp %0d got %0d", exp_w.cmd, m_tuser[7:0]); errors++;
        end
        if (m_tdata[7:0] != exp_w.data) begin
          $error("payload_byte exp %0d got %0d", exp_w.data, m_tdata[7:0]); errors++;
        end
        if (m_tdata[13:8] != exp_w.pos) begin
          $error("byte_position exp %0d got %0d", exp_w.pos, m_tdata[13:8]); errors++;
        end
        if (m_tdata[19:14] != exp_w.len) begin
          $error("payload_length exp %0d got %0d", exp_w.len, m_tdata[19:14]); errors++;
        end
        if (m_tlast != exp_w.fend) begin
          $error("frame_end exp %0d got %0d", exp_w.fend, m_tlast); errors++;
        end
        if (m_tuser[8] != exp_w.rend) begin
          $error("run_end exp %0d got %0d", exp_w.rend, m_tuser[8]); errors++;
        end
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_config_extremes();
    test_random();
    test_backpressure();
    if (pending_words.size() != 0) errors++;
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("== FAIL ==");
    $finish;
  end
endmodule
